FILE: src/ksd_pkg.sv
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types, key codes and display tables for the keypad to segment driver.
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int KEY_COUNT   = 12;
  localparam int WORD_BITS   = 16;
  localparam int CNT_BITS    = $clog2(WORD_BITS);

  localparam logic [3:0] KEY_NONE = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd11;

  typedef logic [3:0] key_code_t;

  // command handed from classifier to shifter
  typedef struct packed {
    logic                 show;
    logic [WORD_BITS-1:0] word;
    logic [2:0]           rgb;
    logic                 mode;
  } ksd_cmd_t;

  // key index (row*3+col) to key code
  function automatic key_code_t index_code(input logic [3:0] idx);
    key_code_t c;
    case (idx)
      4'd9:    c = 4'd10;
      4'd10:   c = 4'd0;
      4'd11:   c = KEY_HASH;
      default: c = 4'(idx + 4'd1);
    endcase
    return c;
  endfunction

  // first pressed key in row-major order, active-low levels
  function automatic key_code_t first_key(input logic [KEY_COUNT-1:0] levels);
    key_code_t c;
    c = KEY_NONE;
    for (int i = KEY_COUNT - 1; i >= 0; i--) begin
      if (!levels[i]) c = index_code(4'(i));
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_seg(input key_code_t k);
    logic [7:0] s;
    case (k)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // keys 1..6 show A..F
  function automatic logic [7:0] letter_seg(input key_code_t k);
    logic [7:0] s;
    case (k)
      4'd1:    s = 8'h88;
      4'd2:    s = 8'h83;
      4'd3:    s = 8'hC6;
      4'd4:    s = 8'hA1;
      4'd5:    s = 8'h86;
      4'd6:    s = 8'h8E;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // red bit 2, green bit 1, blue bit 0
  function automatic logic [2:0] key_colour(input key_code_t k);
    logic [2:0] r;
    case (k)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd4;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd1;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd3;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd4;
      4'd11:   r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/ksd_front.sv
// ----------------------------------------------------------------------------
// ksd_front
// Scan classifier: picks the key, tracks held key, mode and colour, and
// builds the shift word for each accepted scan.
// ----------------------------------------------------------------------------
module ksd_front import ksd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        q_full,
  output logic        q_push,
  output ksd_cmd_t    q_cmd
);

  logic [2:0] digit_position;
  key_code_t  held_key, held_key_next;
  logic       mode_flag, mode_flag_next;
  logic [2:0] rgb_drive, rgb_drive_next;
  key_code_t  key;
  logic       show;
  logic [7:0] seg;
  logic [7:0] sel;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign key      = first_key(s_tdata[KEY_COUNT-1:0]);
  assign sel      = 8'hFF ^ (8'd1 << digit_position);

  always_comb begin
    held_key_next  = held_key;
    mode_flag_next = mode_flag;
    rgb_drive_next = rgb_drive;
    show           = 1'b0;
    seg            = 8'hFF;
    if (key == KEY_NONE) begin
      held_key_next = KEY_NONE;
    end else if (key != held_key) begin
      held_key_next = key;
      if (key == KEY_HASH) begin
        mode_flag_next = !mode_flag;
      end else begin
        if (!mode_flag) begin
          if (key inside {[4'd0:4'd9]}) begin
            show = 1'b1;
            seg  = digit_seg(key);
          end
        end else if (key inside {[4'd1:4'd6]}) begin
          show = 1'b1;
          seg  = letter_seg(key);
        end
        rgb_drive_next = key_colour(key);
      end
    end
  end

  assign q_cmd.show = show;
  assign q_cmd.word = {sel, seg};
  assign q_cmd.rgb  = rgb_drive_next;
  assign q_cmd.mode = mode_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_position <= '0;
      held_key       <= KEY_NONE;
      mode_flag      <= 1'b0;
      rgb_drive      <= '0;
    end else begin
      if (cfg_wr_en) digit_position <= cfg_wr_data;
      if (q_push) begin
        held_key  <= held_key_next;
        mode_flag <= mode_flag_next;
        rgb_drive <= rgb_drive_next;
      end
    end
  end

endmodule

FILE: src/ksd_fifo.sv
// ----------------------------------------------------------------------------
// ksd_fifo
// Two-entry command queue between classifier and shifter.
// ----------------------------------------------------------------------------
module ksd_fifo import ksd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ksd_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output ksd_cmd_t pop_cmd
);

  ksd_cmd_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

FILE: src/ksd_back.sv
// ----------------------------------------------------------------------------
// ksd_back
// Serial shifter: emits one idle beat or sixteen bit beats per command,
// MSB first, from registered outputs.
// ----------------------------------------------------------------------------
module ksd_back import ksd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ksd_cmd_t    q_cmd,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  logic                 busy;
  logic                 show;
  logic [WORD_BITS-1:0] word;
  logic [2:0]           rgb;
  logic                 mode;
  logic [CNT_BITS-1:0]  cnt;
  logic                 last_beat;

  assign last_beat = !show || (cnt == CNT_BITS'(WORD_BITS - 1));
  assign q_pop     = q_valid && (!busy || (m_tready && last_beat));

  assign m_tvalid = busy;
  assign m_tlast  = last_beat;
  // bit 0 serial_bit, 1 bit_valid, 2 red, 3 green, 4 blue, 5 letter_mode
  assign m_tdata  = {2'b00, mode, rgb[0], rgb[1], rgb[2], show,
                     show & word[WORD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_tready) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        cnt <= CNT_BITS'(cnt + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      show <= q_cmd.show;
      word <= q_cmd.word;
      rgb  <= q_cmd.rgb;
      mode <= q_cmd.mode;
    end else if (busy && m_tready && !last_beat) begin
      word <= {word[WORD_BITS-2:0], 1'b0};
    end
  end

endmodule

FILE: src/keypad_to_segment_shift_driver.sv
// ----------------------------------------------------------------------------
// keypad_to_segment_shift_driver
// Keypad scan decoder driving RGB LED, mode flag and a serial display chain.
// ----------------------------------------------------------------------------
// Each input beat is one keypad scan (12 active-low levels). A scan that
// needs no display update yields one idle output beat with tlast set; a new
// digit or letter yields 16 bit beats, select byte then segment byte, MSB
// first, with tlast on the 16th (pulse the latch then). Every beat carries
// the LED and mode state after its scan. The classifier takes a scan per
// cycle while its two-entry queue has room; the shifter emits one beat per
// cycle while m_tready is high, and takes the next command on its last beat.
// digit_position is written through cfg_wr_en/cfg_wr_data.
module keypad_to_segment_shift_driver import ksd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] key_levels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // serial_bit, bit_valid, led_red, led_green,
                                 // led_blue, letter_mode
  output logic        m_tlast,   // latch_last
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);

  ksd_cmd_t push_cmd, pop_cmd;
  logic     push, pop, full, not_empty;

  ksd_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .cfg_wr_en, .cfg_wr_data,
    .q_full(full), .q_push(push), .q_cmd(push_cmd)
  );

  ksd_fifo u_fifo (
    .clk, .rst, .push, .push_cmd, .full, .pop, .not_empty, .pop_cmd
  );

  ksd_back u_back (
    .clk, .rst, .q_valid(not_empty), .q_cmd(pop_cmd), .q_pop(pop),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule
